// ===== hdl/ptd_pkg.sv =====
// Package for the wheel-30 trial-division prime tester: microcode types and program.
`timescale 1ns / 1ps

package ptd_pkg;

    // Step address of the sequencer
    typedef logic [3:0] t_upc;

    // Datapath action of one step
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_SMALL,
        ACT_MOD_START,
        ACT_FOLD_START,
        ACT_TEST_SMALLP,
        ACT_NEXT_SMALLP,
        ACT_SQRT_START,
        ACT_WHEEL_INIT,
        ACT_WHEEL_TOP,
        ACT_WHEEL_TEST,
        ACT_WHEEL_NEXT,
        ACT_EMIT
    } t_act;

    // Jump condition of one step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_FIRE,
        COND_UNIT_IDLE,
        COND_DECIDED,
        COND_MORE_SMALLP,
        COND_OUT_FREE
    } t_cond;

    // Control word: taken jump goes to target, else hold or fall through
    typedef struct packed {
        t_act  act;
        t_cond cond;
        logic  hold;
        t_upc  target;
    } t_cword;

    // Program labels
    localparam t_upc UPC_IDLE       = 4'd0;
    localparam t_upc UPC_SMALL      = 4'd1;
    localparam t_upc UPC_MOD_GO     = 4'd2;
    localparam t_upc UPC_MOD_WAIT   = 4'd3;
    localparam t_upc UPC_TEST_SP    = 4'd4;
    localparam t_upc UPC_NEXT_SP    = 4'd5;
    localparam t_upc UPC_SQRT_GO    = 4'd6;
    localparam t_upc UPC_SQRT_WAIT  = 4'd7;
    localparam t_upc UPC_WHEEL_INIT = 4'd8;
    localparam t_upc UPC_WHEEL_TOP  = 4'd9;
    localparam t_upc UPC_WMOD_GO    = 4'd10;
    localparam t_upc UPC_WMOD_WAIT  = 4'd11;
    localparam t_upc UPC_WTEST      = 4'd12;
    localparam t_upc UPC_WNEXT      = 4'd13;
    localparam t_upc UPC_EMIT       = 4'd14;

    // Wheel constants
    localparam int FIRST_SMALL_PRIME = 3;
    localparam int MID_SMALL_PRIME   = 5;
    localparam int LAST_SMALL_PRIME  = 7;
    localparam int FIRST_WHEEL_BASE  = 11;
    localparam int WHEEL_STEP        = 30;
    localparam logic [2:0] LAST_SPOKE = 3'd7;

    // Offsets of the eight residues coprime to 30 from the block base
    function automatic logic [4:0] wheel_offset(input logic [2:0] k);
        logic [4:0] off;
        unique case (k)
            3'd0:    off = 5'd0;
            3'd1:    off = 5'd2;
            3'd2:    off = 5'd6;
            3'd3:    off = 5'd8;
            3'd4:    off = 5'd12;
            3'd5:    off = 5'd18;
            3'd6:    off = 5'd20;
            default: off = 5'd26;
        endcase
        return off;
    endfunction

    // Microcode ROM
    function automatic t_cword ucode(input t_upc pc);
        t_cword cw;
        unique case (pc)
            UPC_IDLE:       cw = '{ACT_ACCEPT,      COND_IN_FIRE,     1'b1, UPC_SMALL};
            UPC_SMALL:      cw = '{ACT_SMALL,       COND_DECIDED,     1'b0, UPC_EMIT};
            UPC_MOD_GO:     cw = '{ACT_FOLD_START,  COND_NEVER,       1'b0, UPC_IDLE};
            UPC_MOD_WAIT:   cw = '{ACT_NONE,        COND_UNIT_IDLE,   1'b1, UPC_TEST_SP};
            UPC_TEST_SP:    cw = '{ACT_TEST_SMALLP, COND_DECIDED,     1'b0, UPC_EMIT};
            UPC_NEXT_SP:    cw = '{ACT_NEXT_SMALLP, COND_MORE_SMALLP, 1'b0, UPC_MOD_GO};
            UPC_SQRT_GO:    cw = '{ACT_SQRT_START,  COND_NEVER,       1'b0, UPC_IDLE};
            UPC_SQRT_WAIT:  cw = '{ACT_NONE,        COND_UNIT_IDLE,   1'b1, UPC_WHEEL_INIT};
            UPC_WHEEL_INIT: cw = '{ACT_WHEEL_INIT,  COND_NEVER,       1'b0, UPC_IDLE};
            UPC_WHEEL_TOP:  cw = '{ACT_WHEEL_TOP,   COND_DECIDED,     1'b0, UPC_EMIT};
            UPC_WMOD_GO:    cw = '{ACT_MOD_START,   COND_NEVER,       1'b0, UPC_IDLE};
            UPC_WMOD_WAIT:  cw = '{ACT_NONE,        COND_UNIT_IDLE,   1'b1, UPC_WTEST};
            UPC_WTEST:      cw = '{ACT_WHEEL_TEST,  COND_DECIDED,     1'b0, UPC_EMIT};
            UPC_WNEXT:      cw = '{ACT_WHEEL_NEXT,  COND_ALWAYS,      1'b0, UPC_WHEEL_TOP};
            UPC_EMIT:       cw = '{ACT_EMIT,        COND_OUT_FREE,    1'b1, UPC_IDLE};
            default:        cw = '{ACT_NONE,        COND_ALWAYS,      1'b0, UPC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== hdl/ptd_num_if.sv =====
// Input channel carrying the number to test.
`timescale 1ns / 1ps

interface ptd_num_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// ===== hdl/ptd_res_if.sv =====
// Output channel carrying the primality verdict.
`timescale 1ns / 1ps

interface ptd_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hdl/prime_test_trial_division_unit.sv =====
// Numbers up to 3 and even numbers are decided in the small-number step; otherwise the
// 3/5/7 checks use digit folding, the root is taken digit by digit, and trial divisors
// follow, 8 divisors per wheel block of 30 (one remainder bit a cycle). One item at a
// time, the next accepted once the result sits in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps

module prime_test_trial_division_unit import ptd_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ptd_num_if.sink  i_num,
    ptd_res_if.source o_res
);

    localparam int HALF_WIDTH = (VALUE_WIDTH + 1) / 2;
    localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH + 1);

    // Sequencer
    t_upc   r_upc, n_upc;
    t_cword w_cw;
    logic   w_cond;

    // Datapath registers
    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [VALUE_WIDTH-1:0] r_base;
    logic [2:0]             r_k;
    logic                   r_result;

    // Small-prime residue unit
    logic                   r_fold_busy;
    logic [VALUE_WIDTH-1:0] r_fold;
    logic [VALUE_WIDTH-1:0] w_fold_next;
    logic                   w_fold_done;
    logic                   w_fold_zero;

    // Remainder unit for wheel divisors
    logic                   r_div_busy;
    logic [CNT_WIDTH-1:0]   r_div_cnt;
    logic [VALUE_WIDTH-1:0] r_div_rem;
    logic [VALUE_WIDTH-1:0] r_div_sh;
    logic [VALUE_WIDTH:0]   w_div_part;
    logic [VALUE_WIDTH:0]   w_div_diff;

    // Square-root unit
    logic                    r_sq_busy;
    logic [CNT_WIDTH-1:0]    r_sq_cnt;
    logic [HALF_WIDTH:0]     r_sq_rem;
    logic [2*HALF_WIDTH-1:0] r_sq_sh;
    logic [HALF_WIDTH-1:0]   r_root;
    logic [HALF_WIDTH+2:0]   w_sq_part;
    logic [HALF_WIDTH+2:0]   w_sq_trial;

    // Output register
    logic r_out_valid;
    logic r_out_prime;

    logic w_in_fire;
    logic w_out_free;
    logic w_decided;
    logic w_decided_val;
    logic w_le3;

    assign w_cw       = ucode(r_upc);
    assign i_num.ready = (w_cw.act == ACT_ACCEPT);
    assign w_in_fire  = i_num.valid && i_num.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    // Verdicts reached by decision steps
    assign w_le3 = (r_n <= VALUE_WIDTH'(3));
    always_comb begin
        w_decided     = 1'b0;
        w_decided_val = 1'b0;
        unique case (w_cw.act)
            ACT_SMALL: begin
                w_decided     = w_le3 || !r_n[0];
                w_decided_val = w_le3 && (r_n > VALUE_WIDTH'(1));
            end
            ACT_TEST_SMALLP: begin
                w_decided = (r_d != r_n) && w_fold_zero;
            end
            ACT_WHEEL_TOP: begin
                w_decided     = (r_k == 3'd0) && (r_base > VALUE_WIDTH'(r_root));
                w_decided_val = 1'b1;
            end
            ACT_WHEEL_TEST: begin
                w_decided = (r_div_rem == '0);
            end
            default: begin
                w_decided = 1'b0;
            end
        endcase
    end

    // Jump condition select
    always_comb begin
        unique case (w_cw.cond)
            COND_NEVER:       w_cond = 1'b0;
            COND_ALWAYS:      w_cond = 1'b1;
            COND_IN_FIRE:     w_cond = w_in_fire;
            COND_UNIT_IDLE:   w_cond = !r_div_busy && !r_sq_busy && !r_fold_busy;
            COND_DECIDED:     w_cond = w_decided;
            COND_MORE_SMALLP: w_cond = (r_d != VALUE_WIDTH'(LAST_SMALL_PRIME));
            COND_OUT_FREE:    w_cond = w_out_free;
            default:          w_cond = 1'b0;
        endcase
    end

    // Next step address
    always_comb begin
        if (w_cond) begin
            n_upc = w_cw.target;
        end else if (w_cw.hold) begin
            n_upc = r_upc;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Datapath registers driven by the control word
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_n <= i_num.number;
        end
        if (w_decided) begin
            r_result <= w_decided_val;
        end
        unique case (w_cw.act)
            ACT_SMALL: begin
                r_d <= VALUE_WIDTH'(FIRST_SMALL_PRIME);
            end
            ACT_NEXT_SMALLP: begin
                r_d <= r_d + VALUE_WIDTH'(2);
            end
            ACT_WHEEL_INIT: begin
                r_base <= VALUE_WIDTH'(FIRST_WHEEL_BASE);
                r_k    <= 3'd0;
            end
            ACT_WHEEL_TOP: begin
                r_d <= r_base + VALUE_WIDTH'(wheel_offset(r_k));
            end
            ACT_WHEEL_NEXT: begin
                r_k <= r_k + 3'd1;
                if (r_k == LAST_SPOKE) begin
                    r_base <= r_base + VALUE_WIDTH'(WHEEL_STEP);
                end
            end
            default: begin
            end
        endcase
    end

    // Residue by 3, 5 or 7: sum base-2^g digits, since 2^g is 1 mod d
    // (g = 2, 4, 3); stops below 2^g, where d divides only 0, d, 2d, ..., 2^g-1
    always_comb begin
        unique case (r_d)
            VALUE_WIDTH'(FIRST_SMALL_PRIME): begin
                w_fold_next = (r_fold >> 2) + VALUE_WIDTH'(r_fold[1:0]);
                w_fold_done = ((r_fold >> 2) == '0);
                w_fold_zero = (r_fold[1:0] == 2'd0) || (r_fold[1:0] == 2'd3);
            end
            VALUE_WIDTH'(MID_SMALL_PRIME): begin
                w_fold_next = (r_fold >> 4) + VALUE_WIDTH'(r_fold[3:0]);
                w_fold_done = ((r_fold >> 4) == '0);
                w_fold_zero = (r_fold[3:0] == 4'd0) || (r_fold[3:0] == 4'd5) ||
                              (r_fold[3:0] == 4'd10) || (r_fold[3:0] == 4'd15);
            end
            default: begin
                w_fold_next = (r_fold >> 3) + VALUE_WIDTH'(r_fold[2:0]);
                w_fold_done = ((r_fold >> 3) == '0);
                w_fold_zero = (r_fold[2:0] == 3'd0) || (r_fold[2:0] == 3'd7);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_busy <= 1'b0;
        end else if (w_cw.act == ACT_FOLD_START) begin
            r_fold_busy <= 1'b1;
        end else if (r_fold_busy && w_fold_done) begin
            r_fold_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.act == ACT_FOLD_START) begin
            r_fold <= r_n;
        end else if (r_fold_busy && !w_fold_done) begin
            r_fold <= w_fold_next;
        end
    end

    // Restoring remainder: one dividend bit per cycle
    assign w_div_part = {r_div_rem, r_div_sh[VALUE_WIDTH-1]};
    assign w_div_diff = w_div_part - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (w_cw.act == ACT_MOD_START) begin
            r_div_busy <= 1'b1;
        end else if (r_div_busy && r_div_cnt == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.act == ACT_MOD_START) begin
            r_div_rem <= '0;
            r_div_sh  <= r_n;
            r_div_cnt <= '0;
        end else if (r_div_busy) begin
            if (w_div_part >= {1'b0, r_d}) begin
                r_div_rem <= w_div_diff[VALUE_WIDTH-1:0];
            end else begin
                r_div_rem <= w_div_part[VALUE_WIDTH-1:0];
            end
            r_div_sh  <= {r_div_sh[VALUE_WIDTH-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + CNT_WIDTH'(1);
        end
    end

    // Digit-by-digit square root: two radicand bits per cycle
    assign w_sq_part  = {r_sq_rem, r_sq_sh[2*HALF_WIDTH-1 -: 2]};
    assign w_sq_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
        end else if (w_cw.act == ACT_SQRT_START) begin
            r_sq_busy <= 1'b1;
        end else if (r_sq_busy && r_sq_cnt == CNT_WIDTH'(HALF_WIDTH - 1)) begin
            r_sq_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.act == ACT_SQRT_START) begin
            r_sq_rem <= '0;
            r_sq_sh  <= (2*HALF_WIDTH)'(r_n);
            r_root   <= '0;
            r_sq_cnt <= '0;
        end else if (r_sq_busy) begin
            if (w_sq_part >= w_sq_trial) begin
                r_sq_rem <= (HALF_WIDTH+1)'(w_sq_part - w_sq_trial);
                r_root   <= {r_root[HALF_WIDTH-2:0], 1'b1};
            end else begin
                r_sq_rem <= w_sq_part[HALF_WIDTH:0];
                r_root   <= {r_root[HALF_WIDTH-2:0], 1'b0};
            end
            r_sq_sh  <= {r_sq_sh[2*HALF_WIDTH-3:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + CNT_WIDTH'(1);
        end
    end

    // Output register: loaded by the emit step, freed when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cw.act == ACT_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.act == ACT_EMIT && w_out_free) begin
            r_out_prime <= r_result;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.is_prime = r_out_prime;

endmodule

// ===== hdl/ptd_checker.sv =====
// Port-level checks for the prime tester, bound to its top level.
`timescale 1ns / 1ps

module ptd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_prime
);

    logic       w_in_fire;
    logic       w_out_fire;
    logic [1:0] r_pend;

    assign w_in_fire  = i_in_valid && i_in_ready;
    assign w_out_fire = i_out_valid && i_out_ready;

    // Items accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_fire} - {1'b0, w_out_fire};
        end
    end

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_prime))
        else $error("result changed while stalled");

    // One item in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_in_ready)
        else $error("second item taken while one is in work");

    // No result without an item behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire |-> r_pend != 2'd0)
        else $error("result delivered with no item outstanding");

    // A new item only once the previous verdict has left the datapath
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |-> r_pend != 2'd2 && r_pend != 2'd3)
        else $error("item accepted with too many outstanding");

endmodule

bind prime_test_trial_division_unit ptd_checker u_ptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_num.valid),
    .i_in_ready  (i_num.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_prime (o_res.is_prime)
);

// ===== tb/ptd_verdict_checker.sv =====
// Monitor for the prime tester: predicts each verdict and compares it with the output channel.
`timescale 1ns / 1ps

module ptd_verdict_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_num_valid,
    input  logic                   i_num_ready,
    input  logic [VALUE_WIDTH-1:0] i_number,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic                   i_is_prime,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_primes
);

    localparam int REPORT_LIMIT = 10;

    // Offsets of the residues coprime to 30 within one wheel block
    localparam int unsigned SPOKE_OFFSET [8] = '{0, 2, 6, 8, 12, 18, 20, 26};

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] number;
        logic                   is_prime;
    } t_verdict;

    t_verdict verdict_q[$];
    int       fail_count    = 0;
    int       pending_count = 0;
    int       checked_count = 0;
    int       prime_count   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;
    assign o_primes     = prime_count;

    // Trial division over the mod-30 wheel, stopping at the floor square root
    function automatic logic wheel30_is_prime(input logic [VALUE_WIDTH-1:0] number);
        longint unsigned n;
        longint unsigned root;
        longint unsigned cand;
        longint unsigned base;
        longint unsigned d;
        int              b;
        int              k;
        n = 64'(number);
        if (n <= 3)
            return n > 1;
        if (n % 2 == 0)
            return 1'b0;
        for (d = 3; d <= 7; d += 2) begin
            if (n != d && n % d == 0)
                return 1'b0;
        end
        // Floor square root, one bit at a time from the top
        root = 0;
        for (b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= n)
                root = cand;
        end
        for (base = 11; base <= root; base += 30) begin
            for (k = 0; k < 8; k++) begin
                if (n % (base + SPOKE_OFFSET[k]) == 0)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Retire results first so an early result is never matched with a same-cycle number
    always @(posedge i_clk) begin : monitor
        t_verdict oldest;
        t_verdict fresh;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: verdict %0b arrived with no number outstanding",
                                 $time, i_is_prime);
                end else begin
                    oldest = verdict_q.pop_front();
                    checked_count++;
                    if (oldest.is_prime)
                        prime_count++;
                    if (i_is_prime !== oldest.is_prime) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: number %0d is_prime expected %0b, got %0b",
                                     $time, oldest.number, oldest.is_prime, i_is_prime);
                    end
                end
            end
            if (i_num_valid && i_num_ready) begin
                fresh.number   = i_number;
                fresh.is_prime = wheel30_is_prime(i_number);
                verdict_q.push_back(fresh);
            end
            pending_count = verdict_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the prime tester regression: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_WIDTH    = 32;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 75;
    // Slowest item is the 24-bit prime: ~137 wheel blocks of 8 divisors
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int NUM_DIRECTED   = 25;

    // Edge values, primes at the wheel boundaries and squares of primes at the root
    localparam logic [VALUE_WIDTH-1:0] DIRECTED_NUMBERS [NUM_DIRECTED] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd25, 32'd49,
        32'd11, 32'd13, 32'd121, 32'd169, 32'd961, 32'd1681, 32'd5041,
        32'd65521, 32'd65537, 32'd1048573, 32'd1042441, 32'd16777213,
        32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    // Small primes used to build large composites that finish quickly
    localparam int unsigned SMALL_FACTORS [14] = '{
        11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61
    };

    logic i_clk;
    logic i_rst_n;

    ptd_num_if #(.VALUE_WIDTH(VALUE_WIDTH)) num_ch ();
    ptd_res_if res_ch ();

    int tx_idle_pct;
    int rx_stall_pct;
    int idle_cycles = 0;
    int sent_count  = 0;
    int fail_count;
    int pending;
    int checked;
    int primes;

    prime_test_trial_division_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_ch),
        .o_res   (res_ch)
    );

    ptd_verdict_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) verdict_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_valid  (num_ch.valid),
        .i_num_ready  (num_ch.ready),
        .i_number     (num_ch.number),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_is_prime   (res_ch.is_prime),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_primes     (primes)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((num_ch.valid && num_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d verdicts outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("prime_test_trial_division_unit regression: fail");
            $finish;
        end
    end

    // Mostly small numbers; large ones carry a small factor so they resolve fast
    function automatic logic [VALUE_WIDTH-1:0] random_number();
        int unsigned pick;
        int unsigned factor;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        if (pick < 40)
            return $urandom_range(0, 4095);
        if (pick < 60)
            return $urandom_range(4096, 65535);
        if (pick < 85) begin
            factor = SMALL_FACTORS[$urandom_range(0, 13)];
            return factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
        end
        case ($urandom_range(0, 3))
            0:       return r & ~32'd1;
            1:       return r - r % 3;
            2:       return r - r % 5;
            default: return r - r % 7;
        endcase
    endfunction

    // Offer one number, with an optional gap in front, until it is accepted
    task automatic send_number(input logic [VALUE_WIDTH-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            num_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        num_ch.valid  = 1'b1;
        num_ch.number = value;
        do
            @(posedge i_clk);
        while (!num_ch.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    initial begin : stimulus
        int i;
        i_rst_n       = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        tx_idle_pct   = 8;
        rx_stall_pct  = 59;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
            send_number(DIRECTED_NUMBERS[i]);

        // Idle mix changes a third and two thirds of the way through
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                tx_idle_pct  = 59;
                rx_stall_pct = 8;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            send_number(random_number());
        end
        num_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d numbers (%0d directed, %0d random) under three idle mixes",
                 sent_count, NUM_DIRECTED, RANDOM_ITEMS);
        $display("checked %0d verdicts, %0d prime, %0d mismatches",
                 checked, primes, fail_count);
        if (fail_count == 0)
            $display("prime_test_trial_division_unit regression: pass");
        else
            $display("prime_test_trial_division_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ptd_pkg.sv
hdl/ptd_num_if.sv
hdl/ptd_res_if.sv
hdl/prime_test_trial_division_unit.sv
hdl/ptd_checker.sv
tb/ptd_verdict_checker.sv
tb/tb.sv
